FILE: design/annexb_pkg.sv
// Shared types and constants for the Annex B start code parser and unit classifier.
// Used by annexb_front, annexb_queue, annexb_back and the top level; no dependencies.
`default_nettype none

package annexb_pkg;

  // Byte values and type limits of the byte stream format.
  localparam logic [7:0] ZeroByte = 8'h00;
  localparam logic [7:0] MarkByte = 8'h01;
  localparam logic [4:0] TypeMask = 5'h1F;
  localparam logic [4:0] TypeMax  = 5'd23;

  // Unit types that the summary tracks.
  localparam logic [4:0] TypeSliceLo = 5'd1;
  localparam logic [4:0] TypeIdr     = 5'd5;
  localparam logic [4:0] TypeSps     = 5'd7;
  localparam logic [4:0] TypePps     = 5'd8;
  localparam logic [4:0] TypeAud     = 5'd9;

  localparam logic [7:0] CountMax = 8'hFF;

  // One parsed event from the front part: a header byte, a payload end, or both.
  typedef struct packed {
    logic       found;
    logic [4:0] kind;
    logic       last;
  } event_t;

  // One result item as presented on the output ports.
  typedef struct packed {
    logic       unit_found;
    logic [4:0] unit_type;
    logic       payload_done;
    logic       saw_idr;
    logic       saw_sps;
    logic       saw_pps;
    logic       saw_delimiter;
    logic       slice_type_valid;
    logic [2:0] first_slice_type;
    logic [7:0] unit_count;
  } result_t;

endpackage

`default_nettype wire

FILE: design/annexb_nal_unit_classifier_core.sv
// Top level of the Annex B start code parser and unit classifier.
// Depends on annexb_pkg, annexb_front, annexb_queue and annexb_back.
`default_nettype none

// The block takes one payload byte per item through a queue-style input (push, full) and
// delivers result items through a queue-style output (empty, pop). A run of two or more
// zero bytes followed by 01 is a start code, and the byte after it is a unit header; each
// header yields a result with its unit type (low five bits, types above 23 shown as 0).
// The byte flagged last_byte_i yields a result carrying the payload summary: IDR, SPS,
// PPS and delimiter flags, the first slice type, and a unit count saturating at 255. A
// header that is also the last byte gives one result with both parts. Bytes that are
// neither produce nothing. The block sustains one byte per clock cycle while full is low:
// the front part updates the two-bit zero run and the header flag, and the back part
// updates the summary and its output register. A result passes through the event queue
// and the output register before it reaches the output ports. The event queue of
// QueueDepth entries between the two parts and the output register together hold
// QueueDepth + 1 result items while the output side stalls; full rises once the queue
// itself is full, whether or not the next byte would produce a result.
module annexb_nal_unit_classifier_core #(
  parameter int QueueDepth = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input byte channel.
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  byte_value_i,
  input  wire         last_byte_i,
  // Result channel.
  output logic        empty,
  input  wire         pop,
  output logic        unit_found_o,
  output logic [4:0]  unit_type_o,
  output logic        payload_done_o,
  output logic        saw_idr_o,
  output logic        saw_sps_o,
  output logic        saw_pps_o,
  output logic        saw_delimiter_o,
  output logic        slice_type_valid_o,
  output logic [2:0]  first_slice_type_o,
  output logic [7:0]  unit_count_o
);
  import annexb_pkg::*;

  logic    q_full, q_empty, q_wr, q_rd, front_accept, out_valid;
  event_t  q_wr_data, q_rd_data;
  result_t res;

  // The front part classifies each byte and queues an event only for headers and
  // payload ends, so full only depends on the queue.
  annexb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .byte_value_i(byte_value_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .accept_o    (front_accept),
    .q_wr_o      (q_wr),
    .q_data_o    (q_wr_data)
  );

  annexb_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_data_i(q_wr_data),
    .rd_i     (q_rd),
    .rd_data_o(q_rd_data),
    .full_o   (q_full),
    .empty_o  (q_empty)
  );

  // The back part keeps the running summary and the output register.
  annexb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rd_data),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .out_valid_o(out_valid),
    .out_o      (res)
  );

  assign full               = q_full;
  assign empty              = !out_valid;
  assign unit_found_o       = res.unit_found;
  assign unit_type_o        = res.unit_type;
  assign payload_done_o     = res.payload_done;
  assign saw_idr_o          = res.saw_idr;
  assign saw_sps_o          = res.saw_sps;
  assign saw_pps_o          = res.saw_pps;
  assign saw_delimiter_o    = res.saw_delimiter;
  assign slice_type_valid_o = res.slice_type_valid;
  assign first_slice_type_o = res.first_slice_type;
  assign unit_count_o       = res.unit_count;

`ifndef NO_ASSERTIONS
  a_accept_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_accept == (push && !full)) else $error("input accept mismatch");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr |-> !q_full) else $error("event written into a full queue");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(!q_empty)) else $error("result appeared without a queued event");
`endif

endmodule

`default_nettype wire

FILE: design/annexb_front.sv
// Front part: accepts payload bytes, tracks the zero run and classifies header bytes.
// Depends on annexb_pkg; writes event_t records into annexb_queue.
`default_nettype none

module annexb_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire  [7:0]           byte_value_i,
  input  wire                  last_byte_i,
  input  wire                  q_full_i,
  output logic                 accept_o,
  output logic                 q_wr_o,
  output annexb_pkg::event_t   q_data_o
);
  import annexb_pkg::*;

  logic [1:0] zero_run_q, zero_run_d;
  logic       header_next_q, header_next_d;
  logic [4:0] kind_raw;

  assign accept_o = push_i && !q_full_i;
  assign kind_raw = byte_value_i[4:0] & TypeMask;

  always_comb begin
    q_data_o.found = header_next_q;
    q_data_o.kind  = (header_next_q && kind_raw <= TypeMax) ? kind_raw : 5'd0;
    q_data_o.last  = last_byte_i;
  end

  assign q_wr_o = accept_o && (header_next_q || last_byte_i);

  always_comb begin
    zero_run_d    = zero_run_q;
    header_next_d = header_next_q;
    if (accept_o) begin
      if (last_byte_i) begin
        // Every payload is parsed on its own.
        zero_run_d    = 2'd0;
        header_next_d = 1'b0;
      end else if (header_next_q) begin
        // A header byte never counts toward the next start code.
        zero_run_d    = 2'd0;
        header_next_d = 1'b0;
      end else if (byte_value_i == ZeroByte) begin
        zero_run_d = (zero_run_q == 2'd2) ? 2'd2 : zero_run_q + 2'd1;
      end else begin
        header_next_d = (byte_value_i == MarkByte) && (zero_run_q == 2'd2);
        zero_run_d    = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q    <= 2'd0;
      header_next_q <= 1'b0;
    end else begin
      zero_run_q    <= zero_run_d;
      header_next_q <= header_next_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/annexb_queue.sv
// Short event queue between the front and back parts.
// Depends on annexb_pkg for the event_t record.
`default_nettype none

module annexb_queue #(
  parameter int Depth = 4
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  wr_i,
  input  annexb_pkg::event_t   wr_data_i,
  input  wire                  rd_i,
  output annexb_pkg::event_t   rd_data_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import annexb_pkg::*;

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  DepthCnt = CntW'(Depth);

  event_t           slots_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == DepthCnt);
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt) else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not grow on a write");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == DepthCnt) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with the count");
`endif

endmodule

`default_nettype wire

FILE: design/annexb_back.sv
// Back part: folds queued events into the per-payload summary and holds the result item.
// Depends on annexb_pkg; reads event_t records from annexb_queue.
`default_nettype none

module annexb_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  q_empty_i,
  input  annexb_pkg::event_t   q_data_i,
  output logic                 q_rd_o,
  input  wire                  pop_i,
  output logic                 out_valid_o,
  output annexb_pkg::result_t  out_o
);
  import annexb_pkg::*;

  logic [3:0] flags_q, flags_d;    // bit0 IDR, bit1 SPS, bit2 PPS, bit3 AUD
  logic [2:0] first_q, first_d;
  logic [7:0] count_q, count_d;
  logic       valid_q;
  result_t    res_q, res_d;

  // The output register refills in the same cycle that its item is popped, if the queue holds an event.
  assign q_rd_o      = !q_empty_i && (!valid_q || pop_i);
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_comb begin
    flags_d = flags_q;
    first_d = first_q;
    count_d = count_q;
    if (q_data_i.found) begin
      if (count_q != CountMax) begin
        count_d = count_q + 8'd1;
      end
      unique case (q_data_i.kind)
        TypeIdr: flags_d[0] = 1'b1;
        TypeSps: flags_d[1] = 1'b1;
        TypePps: flags_d[2] = 1'b1;
        TypeAud: flags_d[3] = 1'b1;
        default: ;
      endcase
      if (q_data_i.kind >= TypeSliceLo && q_data_i.kind <= TypeIdr && first_q == 3'd0) begin
        first_d = q_data_i.kind[2:0];
      end
    end

    res_d                  = '0;
    res_d.unit_found       = q_data_i.found;
    res_d.unit_type        = q_data_i.kind;
    if (q_data_i.last) begin
      res_d.payload_done     = 1'b1;
      res_d.saw_idr          = flags_d[0];
      res_d.saw_sps          = flags_d[1];
      res_d.saw_pps          = flags_d[2];
      res_d.saw_delimiter    = flags_d[3];
      res_d.slice_type_valid = (first_d != 3'd0);
      res_d.first_slice_type = first_d;
      res_d.unit_count       = count_d;
      flags_d = '0;
      first_d = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      first_q <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (q_rd_o) begin
        flags_q <= flags_d;
        first_q <= first_d;
        count_q <= count_d;
      end
      if (q_rd_o) begin
        valid_q <= 1'b1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !pop_i) |=> (valid_q && res_q == $past(res_q)))
    else $error("waiting result changed before it was taken");

  a_summary_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_rd_o && q_data_i.last) |=> (count_q == '0 && flags_q == '0 && first_q == '0))
    else $error("summary not cleared at payload end");

  a_report_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (res_q.unit_type <= TypeMax && (res_q.unit_found || res_q.payload_done)))
    else $error("result item without a header or payload end");
`endif

endmodule

`default_nettype wire
